@@ hdl/gpa_pkg.sv @@
// Shared constants, operation and status codes, and types for the GF(2) polynomial ALU.
package gpa_pkg;

  localparam int POLY_W      = 32;
  localparam int CNT_W       = $clog2(POLY_W);
  localparam int SMEAR_STEPS = $clog2(POLY_W);

  localparam logic [8:0] AES_MODULUS = 9'h11B;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_MUL = 3'd1;
  localparam logic [2:0] MODE_QUO = 3'd2;
  localparam logic [2:0] MODE_REM = 3'd3;
  localparam logic [2:0] MODE_AES = 3'd4;
  localparam logic [2:0] MODE_PWR = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVFL    = 2'd1;
  localparam logic [1:0] STATUS_DIVZERO = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } gpa_unit_stat_t;

endpackage

@@ hdl/gpa_clmul.sv @@
// Bit-serial carry-less multiplier producing the full double-width product.
module gpa_clmul import gpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [POLY_W-1:0]     mcand_i,
  input  logic [POLY_W-1:0]     mplier_i,
  output gpa_unit_stat_t        stat_o,
  output logic [2*POLY_W-1:0]   prod_o
);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [2*POLY_W-1:0] acc_q, acc_d;
  logic [POLY_W-1:0]   mpl_q, mpl_d;
  logic [POLY_W-1:0]   mcd_q;

  // Horner form: multiplier bits enter most significant first.
  always_comb begin
    acc_d = {acc_q[2*POLY_W-2:0], 1'b0};
    if (mpl_q[POLY_W-1]) begin
      acc_d = acc_d ^ {{POLY_W{1'b0}}, mcd_q};
    end
    mpl_d = {mpl_q[POLY_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(POLY_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mpl_q <= mplier_i;
      mcd_q <= mcand_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      mpl_q <= mpl_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

@@ hdl/gpa_divider.sv @@
// Bit-serial polynomial long divider with a short leading-term search before the division.
module gpa_divider import gpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [POLY_W-1:0] dividend_i,
  input  logic [POLY_W-1:0] divisor_i,
  output gpa_unit_stat_t    stat_o,
  output logic [POLY_W-1:0] quo_o,
  output logic [POLY_W-1:0] rem_o
);

  logic              smear_q;
  logic              div_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [POLY_W-1:0] num_q, num_d;
  logic [POLY_W-1:0] rem_q, rem_d;
  logic [POLY_W-1:0] dvs_q;
  logic [POLY_W-1:0] smr_q, smr_d;
  logic [POLY_W-1:0] lead;
  logic [POLY_W-1:0] trial;
  logic              hit;

  // The smear fills every bit below the divisor's leading term; its top edge marks that term.
  assign smr_d = smr_q | (smr_q >> (1 << cnt_q));
  assign lead  = smr_q & ~(smr_q >> 1);

  // One dividend bit enters per cycle; the divisor is subtracted when the leading term appears.
  always_comb begin
    trial = {rem_q[POLY_W-2:0], num_q[POLY_W-1]};
    hit   = |(trial & lead);
    rem_d = hit ? (trial ^ dvs_q) : trial;
    num_d = {num_q[POLY_W-2:0], hit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smear_q <= 1'b0;
      div_q   <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= div_q && (cnt_q == '0);
      if (start_i) begin
        smear_q <= 1'b1;
        cnt_q   <= '0;
      end else if (smear_q) begin
        if (cnt_q == CNT_W'(SMEAR_STEPS - 1)) begin
          smear_q <= 1'b0;
          div_q   <= 1'b1;
          cnt_q   <= CNT_W'(POLY_W - 1);
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (div_q) begin
        if (cnt_q == '0) begin
          div_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      smr_q <= divisor_i;
    end else if (smear_q) begin
      smr_q <= smr_d;
    end else if (div_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = smear_q | div_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;
  assign rem_o       = rem_q;

endmodule

@@ hdl/gf2_polynomial_alu_unit.sv @@
// Top level of the GF(2) polynomial ALU: control sequencer, shared serial units, output register.
//
// Usage: one transaction on the input channel (in_valid_i, in_stall_o) carries mode_i,
// operand_a_i and operand_b_i; exactly one transaction on the output channel (out_valid_o,
// out_stall_i) returns result_o and status_o for it, in order. Only one operation is in
// flight; in_stall_o is high from the acceptance edge until the result has moved into the
// output register, which may still be waiting for the receiver when the next input is taken.
// From acceptance to out_valid_o:
//   add and the unused modes, and every case settled at once (divide by zero, trivial
//   power): the result is registered at acceptance, then loaded into the output register.
//   multiply: runs in the bit-serial multiplier (one multiplier bit a cycle).
//   quotient and remainder: a leading-term search followed by one dividend bit per cycle
//   in the serial divider.
//   AES multiply: a full multiply and then a serial reduction by 0x11B.
//   power: one multiplication per unit of the exponent; the loop stops at the first
//   product of degree 32 or more, so at most 32 multiplications run.
// A nonzero status always comes with a zero result.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties the output
// register; no clearing pass is needed. While out_stall_i is high the output register holds
// its transaction and a finished result waits in the sequencer, so nothing is lost.
module gf2_polynomial_alu_unit import gpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        mode_i,
  input  logic [POLY_W-1:0] operand_a_i,
  input  logic [POLY_W-1:0] operand_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [POLY_W-1:0] result_o,
  output logic [1:0]        status_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_PWR  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [2:0]          mode_q, mode_d;
  logic [POLY_W-1:0]   a_q, a_d;
  logic [POLY_W-1:0]   b_q, b_d;
  logic [POLY_W-1:0]   res_q, res_d;
  logic [1:0]          sta_q, sta_d;
  logic                out_valid_q, out_valid_d;
  logic [POLY_W-1:0]   out_res_q;
  logic [1:0]          out_sta_q;

  logic                in_accept;
  logic                out_free;
  logic                out_load;

  logic                mul_start;
  logic [POLY_W-1:0]   mul_mcand;
  logic [POLY_W-1:0]   mul_mplier;
  gpa_unit_stat_t      mul_stat;
  logic [2*POLY_W-1:0] mul_prod;
  logic                mul_ovfl;

  logic                div_start;
  logic [POLY_W-1:0]   div_dividend;
  logic [POLY_W-1:0]   div_divisor;
  gpa_unit_stat_t      div_stat;
  logic [POLY_W-1:0]   div_quo;
  logic [POLY_W-1:0]   div_rem;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;

  // A carry-less product has degree deg(a) + deg(b) exactly, so any bit in the upper half
  // means the true result does not fit.
  assign mul_ovfl = |mul_prod[2*POLY_W-1:POLY_W];

  // The power loop multiplies the running result by the stored base; every other multiply
  // takes the operands straight from the input ports at acceptance.
  assign mul_mcand  = (state_q == ST_PWR) ? a_q : operand_a_i;
  assign mul_mplier = (state_q == ST_PWR) ? res_q : operand_b_i;

  // The AES reduction reuses the divider with the field polynomial as divisor.
  assign div_dividend = (state_q == ST_MUL) ? mul_prod[POLY_W-1:0] : operand_a_i;
  assign div_divisor  = (state_q == ST_MUL) ? POLY_W'(AES_MODULUS) : operand_b_i;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    a_d       = a_q;
    b_d       = b_q;
    res_d     = res_q;
    sta_d     = sta_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mode_d  = mode_i;
          a_d     = operand_a_i;
          b_d     = operand_b_i;
          res_d   = '0;
          sta_d   = STATUS_OK;
          state_d = ST_DONE;
          unique case (mode_i) inside
            MODE_ADD: begin
              res_d = operand_a_i ^ operand_b_i;
            end
            MODE_MUL, MODE_AES: begin
              mul_start = 1'b1;
              state_d   = ST_MUL;
            end
            MODE_QUO, MODE_REM: begin
              if (operand_b_i == '0) begin
                sta_d = STATUS_DIVZERO;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            MODE_PWR: begin
              // Zero exponent, and a base of one, give one; a zero base gives zero.
              if (operand_b_i == '0 || operand_a_i == POLY_W'(1)) begin
                res_d = POLY_W'(1);
              end else if (operand_a_i != '0) begin
                res_d   = POLY_W'(1);
                state_d = ST_PWR;
              end
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end
      ST_PWR: begin
        mul_start = 1'b1;
        b_d       = b_q - 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          if (mul_ovfl) begin
            res_d   = '0;
            sta_d   = STATUS_OVFL;
            state_d = ST_DONE;
          end else begin
            unique case (mode_q) inside
              MODE_AES: begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
              MODE_PWR: begin
                res_d   = mul_prod[POLY_W-1:0];
                state_d = (b_q == '0) ? ST_DONE : ST_PWR;
              end
              default: begin
                res_d   = mul_prod[POLY_W-1:0];
                state_d = ST_DONE;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_d   = (mode_q == MODE_QUO) ? div_quo : div_rem;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    sta_q  <= sta_d;
    if (out_load) begin
      out_res_q <= res_q;
      out_sta_q <= sta_q;
    end
  end

  gpa_clmul u_clmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .stat_o   (mul_stat),
    .prod_o   (mul_prod)
  );

  gpa_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign out_valid_o = out_valid_q;
  assign result_o    = out_res_q;
  assign status_o    = out_sta_q;

  // Any error status must come with a cleared result.
  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |-> (result_o == '0))
    else $error("error status delivered with a nonzero result");

  // The multiplier finishes only while the sequencer waits for it.
  a_mul_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside the multiply state");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  // A reduction modulo the AES polynomial leaves a remainder of degree below eight.
  a_aes_rem_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_stat.done && mode_q == MODE_AES)
      |-> (div_rem[POLY_W-1:8] == '0))
    else $error("AES reduction left a remainder of degree eight or more");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the GF(2) polynomial ALU unit: stimulus, prediction and checking.
module testbench;
  import gpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_OPS     = 1125;
  // Every drain point makes the sender wait until all results are back.
  localparam int DRAIN_EVERY    = 250;
  // One long receiver hold-off starts once this many transactions have gone in.
  localparam int HOLDOFF_AFTER  = 500;
  localparam int HOLDOFF_CYCLES = 600;
  // The slowest operation is a power with 32 multiplications.
  localparam int TAIL_CYCLES    = 1200;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic              drain_first;
    logic [2:0]        mode;
    logic [POLY_W-1:0] a;
    logic [POLY_W-1:0] b;
  } gf2_op_t;

  typedef struct packed {
    logic [POLY_W-1:0] value;
    logic [1:0]        status;
  } gf2_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [2:0]        mode_i      = MODE_ADD;
  logic [POLY_W-1:0] operand_a_i = '0;
  logic [POLY_W-1:0] operand_b_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [POLY_W-1:0] result_o;
  logic [1:0]        status_o;

  gf2_op_t     ops_to_send[$];
  gf2_result_t gf2_results_due[$];
  gf2_op_t     op_on_bus;

  int mismatch_count = 0;
  int ops_accepted   = 0;
  int results_seen   = 0;
  int overflow_seen  = 0;
  int divzero_seen   = 0;
  int mode_count[8];

  int burst_left   = 1;
  int idle_left    = 0;
  int stall_style  = 0;
  int phase_left   = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int quiet_cycles = 0;

  gf2_polynomial_alu_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .status_o    (status_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Polynomial arithmetic used to predict each result. Polynomials are held in
  // 64 bits so that a product can be formed in full before the overflow check.
  // ---------------------------------------------------------------------------

  // Degree of a polynomial; -1 for the zero polynomial.
  function automatic int poly_deg(logic [63:0] p);
    int d = -1;
    for (int k = 0; k < 64; k++)
      if (p[k]) d = k;
    return d;
  endfunction

  // Carry-less product, not truncated.
  function automatic logic [63:0] carryless_mul(logic [63:0] x, logic [63:0] y);
    logic [63:0] acc = '0;
    for (int i = 0; i < POLY_W; i++)
      if (y[i]) acc ^= x << i;
    return acc;
  endfunction

  // A product overflows when both factors are nonzero and their degrees add up
  // to the polynomial width or beyond.
  function automatic bit product_overflows(logic [63:0] x, logic [63:0] y);
    return x != 0 && y != 0 && poly_deg(x) + poly_deg(y) >= POLY_W;
  endfunction

  // Schoolbook long division; the divisor is never zero here.
  function automatic void poly_divide(input logic [63:0] num, input logic [63:0] den,
                                      output logic [63:0] quo, output logic [63:0] rem);
    int dd = poly_deg(den);
    int shift;
    quo = '0;
    rem = num;
    while (rem != 0 && poly_deg(rem) >= dd) begin
      shift = poly_deg(rem) - dd;
      quo[shift] = 1'b1;
      rem ^= den << shift;
    end
  endfunction

  // Expected result and status of one operation.
  function automatic gf2_result_t gf2_alu_result(gf2_op_t op);
    gf2_result_t res;
    logic [63:0] a, b, q, r, p;
    int da;
    res.value  = '0;
    res.status = STATUS_OK;
    a = 64'(op.a);
    b = 64'(op.b);
    case (op.mode)
      MODE_ADD: begin
        res.value = op.a ^ op.b;
      end
      MODE_MUL: begin
        if (product_overflows(a, b)) begin
          res.status = STATUS_OVFL;
        end else begin
          p = carryless_mul(a, b);
          res.value = p[POLY_W-1:0];
        end
      end
      MODE_QUO, MODE_REM: begin
        if (b == 0) begin
          res.status = STATUS_DIVZERO;
        end else begin
          poly_divide(a, b, q, r);
          res.value = (op.mode == MODE_QUO) ? q[POLY_W-1:0] : r[POLY_W-1:0];
        end
      end
      MODE_AES: begin
        // Full carry-less product, then the remainder modulo x^8+x^4+x^3+x+1.
        if (product_overflows(a, b)) begin
          res.status = STATUS_OVFL;
        end else begin
          poly_divide(carryless_mul(a, b), 64'(AES_MODULUS), q, r);
          res.value = r[POLY_W-1:0];
        end
      end
      MODE_PWR: begin
        // The exponent is an integer. Anything to the zeroth power is one, zero to a
        // positive power is zero, and a constant base of one stays one.
        if (b == 0) begin
          res.value = 1;
        end else if (a == 0) begin
          res.value = 0;
        end else begin
          da = poly_deg(a);
          if (da == 0) begin
            res.value = 1;
          end else if (b > 64'((POLY_W - 1) / da)) begin
            res.status = STATUS_OVFL;
          end else begin
            p = 64'd1;
            for (int k = 0; k < int'(b); k++) p = carryless_mul(p, a);
            res.value = p[POLY_W-1:0];
          end
        end
      end
      default: begin
        // Modes 6 and 7 are unused and return zero with an ok status.
        res.value = '0;
      end
    endcase
    if (res.status != STATUS_OK) res.value = '0;
    return res;
  endfunction

  // Random polynomial of exactly the given degree; zero for a negative degree.
  function automatic logic [POLY_W-1:0] poly_of_degree(int d);
    logic [POLY_W-1:0] top;
    if (d < 0) return '0;
    top = POLY_W'(1) << d;
    return top | (POLY_W'($urandom) & (top - 1'b1));
  endfunction

  task automatic queue_op(logic [2:0] mode, logic [POLY_W-1:0] a, logic [POLY_W-1:0] b,
                          logic drain_first = 1'b0);
    gf2_op_t op;
    op.drain_first = drain_first;
    op.mode        = mode;
    op.a           = a;
    op.b           = b;
    ops_to_send.push_back(op);
  endtask

  task automatic flag_mismatch(string what, logic [POLY_W-1:0] got, logic [POLY_W-1:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver. The sender offers transactions in bursts of random length with random
  // gaps between them. A stalled transaction holds its payload. An item marked
  // drain_first is not offered until every outstanding result has come back.
  // The expectation is computed at the edge where the transaction is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_inputs
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        gf2_results_due.push_back(gf2_alu_result(op_on_bus));
        ops_accepted++;
        mode_count[op_on_bus.mode]++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (ops_to_send.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (ops_to_send[0].drain_first && gf2_results_due.size() != 0) begin
          in_valid_i <= 1'b0;
        end else begin
          op_on_bus = ops_to_send.pop_front();
          in_valid_i  <= 1'b1;
          mode_i      <= op_on_bus.mode;
          operand_a_i <= op_on_bus.a;
          operand_b_i <= op_on_bus.b;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // About a quarter of the bursts run straight into the next one.
            idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. The stall pattern changes style in phases of random length: never,
  // rarely, mostly, or alternating. Once, a long hold-off keeps the output
  // stalled while the sender keeps offering, so the unit fills and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    logic stall_next;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!holdoff_done && ops_accepted >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        stall_next = 1'b1;
      end else begin
        if (phase_left <= 0) begin
          stall_style = $urandom_range(0, 3);
          phase_left  = $urandom_range(40, 400);
        end else begin
          phase_left--;
        end
        case (stall_style)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ~out_stall_i;
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each accepted output transaction is checked against the oldest
  // outstanding expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_outputs
    gf2_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (gf2_results_due.size() == 0) begin
        flag_mismatch("result with no operation outstanding", result_o, '0);
      end else begin
        want = gf2_results_due.pop_front();
        if (result_o !== want.value) flag_mismatch("result", result_o, want.value);
        if (status_o !== want.status)
          flag_mismatch("status", POLY_W'(status_o), POLY_W'(want.status));
        if (want.status == STATUS_OVFL) overflow_seen++;
        if (want.status == STATUS_DIVZERO) divzero_seen++;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, gf2_results_due.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of the run.
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int pick, da, db;
    logic [2:0] mode;
    logic [POLY_W-1:0] a, b;

    foreach (mode_count[m]) mode_count[m] = 0;

    // Directed part: field extremes, every operation and the special cases.
    queue_op(MODE_ADD, '0, '0);
    queue_op(MODE_ADD, '1, '1);
    queue_op(MODE_ADD, '1, '0);
    queue_op(MODE_MUL, '0, 32'h1234_5678);              // zero factor
    queue_op(MODE_MUL, '1, 32'h1);                      // degree 31 exactly
    queue_op(MODE_MUL, 32'h0001_0000, 32'h0000_8000);   // degrees add to 31
    queue_op(MODE_MUL, 32'h8000_0000, 32'h2);           // degrees add to 32
    queue_op(MODE_QUO, 32'hDEAD_BEEF, '0);              // divide by zero
    queue_op(MODE_REM, '1, '0);                         // divide by zero
    queue_op(MODE_QUO, '1, 32'h1);
    queue_op(MODE_REM, '1, 32'h0000_011B);
    queue_op(MODE_QUO, 32'h5, 32'h8000_0000);           // divisor of higher degree
    queue_op(MODE_REM, '0, '1);
    queue_op(MODE_AES, 32'h57, 32'h83);
    queue_op(MODE_AES, 32'h53, 32'hCA);
    queue_op(MODE_AES, 32'hFFFF, 32'hFFFF);
    queue_op(MODE_AES, 32'h8000_0000, 32'h2);           // product overflows
    queue_op(MODE_PWR, '1, '0);                         // anything to the zeroth power
    queue_op(MODE_PWR, '0, 32'h5);                      // zero base
    queue_op(MODE_PWR, 32'h1, '1);                      // constant base of one
    queue_op(MODE_PWR, 32'h2, 32'd31);                  // x^31
    queue_op(MODE_PWR, 32'h3, 32'd32);                  // power overflow
    queue_op(MODE_PWR, '1, 32'h1);
    queue_op(MODE_PWR, 32'h6, '1);                      // huge exponent
    queue_op(3'd6, '1, '1);                             // unused modes
    queue_op(3'd7, 32'hA5A5_A5A5, 32'h5A5A_5A5A);

    // Random part. Operand degrees are chosen so that most products stay within
    // the width, with a share that overflows on purpose.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      a = $urandom;
      b = $urandom;
      if (pick < 12) begin
        mode = MODE_ADD;
      end else if (pick < 32 || (pick >= 66 && pick < 78)) begin
        mode = (pick < 32) ? MODE_MUL : MODE_AES;
        if (mode == MODE_AES && $urandom_range(0, 1) == 0) begin
          a = poly_of_degree($urandom_range(0, 7));
          b = poly_of_degree($urandom_range(0, 7));
        end else if ($urandom_range(0, 5) != 0) begin
          da = $urandom_range(0, POLY_W - 1);
          db = ($urandom_range(0, 4) == 0) ? $urandom_range(0, POLY_W - 1)
                                           : $urandom_range(0, POLY_W - 1 - da);
          a = poly_of_degree(da);
          b = poly_of_degree(db);
        end
        if ($urandom_range(0, 19) == 0) a = '0;
        if ($urandom_range(0, 19) == 0) b = '0;
      end else if (pick < 66) begin
        mode = (pick < 50) ? MODE_QUO : MODE_REM;
        if ($urandom_range(0, 1) == 0) a = poly_of_degree(int'($urandom_range(0, POLY_W)) - 1);
        if ($urandom_range(0, 15) == 0) b = '0;
        else if ($urandom_range(0, 1) == 0) b = poly_of_degree($urandom_range(0, 8));
        else b = poly_of_degree($urandom_range(0, POLY_W - 1));
      end else if (pick < 94) begin
        mode = MODE_PWR;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          b = '0;
        end else if (pick < 3) begin
          a = '0;
        end else if (pick < 4) begin
          a = 32'h1;
        end else if (pick < 6) begin
          a = poly_of_degree($urandom_range(1, POLY_W - 1));    // huge exponent
        end else begin
          da = $urandom_range(1, POLY_W - 1);
          a = poly_of_degree(da);
          b = $urandom_range(0, (POLY_W - 1) / da + 1);
        end
      end else begin
        mode = 3'($urandom_range(6, 7));
      end
      queue_op(mode, a, b, (n % DRAIN_EVERY) == 0);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid_i || gf2_results_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations: add %0d, multiply %0d, quotient %0d, remainder %0d, aes %0d,",
             ops_accepted, mode_count[MODE_ADD], mode_count[MODE_MUL], mode_count[MODE_QUO],
             mode_count[MODE_REM], mode_count[MODE_AES]);
    $display("power %0d, unused %0d; %0d results checked, %0d overflow, %0d divide by zero.",
             mode_count[MODE_PWR], mode_count[6] + mode_count[7], results_seen,
             overflow_seen, divzero_seen);
    if (mismatch_count == 0 && gf2_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gpa_pkg.sv
hdl/gpa_clmul.sv
hdl/gpa_divider.sv
hdl/gf2_polynomial_alu_unit.sv
tb/sv/testbench.sv
